// ----- sv/xtea_pkg.sv -----
// Package for the XTEA block cipher: types, round constants and helpers.
// The pipeline stage, the key registers and the top level all depend on it; it has no dependencies.
package xtea_pkg;

  localparam int unsigned CYCLES      = 32;
  localparam int unsigned HALF_ROUNDS = 2 * CYCLES;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned IDX_W       = $clog2(KEY_WORDS);

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef enum logic [IDX_W-1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } key_idx_e;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } stage_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Running sum seen by half-round s of an encryption.
  function automatic logic [WORD_W-1:0] enc_sum(input int unsigned s);
    logic [WORD_W-1:0] n;
    n = WORD_W'(s >> 1) + WORD_W'(s & 1);
    return WORD_W'(DELTA * n);
  endfunction

  // Running sum seen by half-round s of a decryption.
  function automatic logic [WORD_W-1:0] dec_sum(input int unsigned s);
    logic [WORD_W-1:0] n;
    n = WORD_W'(CYCLES) - WORD_W'(s >> 1) - WORD_W'(s & 1);
    return WORD_W'(DELTA * n);
  endfunction

  function automatic logic [IDX_W-1:0] enc_ksel(input int unsigned s);
    logic [WORD_W-1:0] sm;
    sm = enc_sum(s);
    return ((s & 1) == 0) ? sm[1:0] : sm[12:11];
  endfunction

  function automatic logic [IDX_W-1:0] dec_ksel(input int unsigned s);
    logic [WORD_W-1:0] sm;
    sm = dec_sum(s);
    return ((s & 1) == 0) ? sm[12:11] : sm[1:0];
  endfunction

endpackage

// ----- sv/xtea_block_cipher_top.sv -----
// Top level of the XTEA block cipher: key registers and 64 half-round stages.
// Depends on xtea_pkg, xtea_key_regs and xtea_half_round.
//
//   channel | signals                                     | direction
//   in      | in_valid_i, in_ready_o, op_i, block_hi/lo_i | transaction in
//   out     | out_valid_o, out_ready_i, result_hi/lo_o    | transaction out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i            | key write
//
// One register per half-round; one block per cycle sustained while the result is not stalled.
// Reset clears the stage valid bits and the key words to zero.
// A stalled result freezes every stage; the first stage still loads when empty.
module xtea_block_cipher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [xtea_pkg::WORD_W-1:0] block_hi_i,
  input  logic [xtea_pkg::WORD_W-1:0] block_lo_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [xtea_pkg::WORD_W-1:0] result_hi_o,
  output logic [xtea_pkg::WORD_W-1:0] result_lo_o,
  input  logic                        cfg_we_i,
  input  logic [xtea_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0] cfg_wdata_i
);

  localparam int unsigned N = xtea_pkg::HALF_ROUNDS;

  xtea_pkg::key_t   key;
  xtea_pkg::stage_t in_data;
  xtea_pkg::stage_t st_data [N];
  logic [N-1:0]     st_vld;
  logic             advance;

  xtea_key_regs u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  assign advance    = !st_vld[N-1] || out_ready_i;
  assign in_ready_o = advance || !st_vld[0];
  assign in_data    = '{op: op_i, v0: block_hi_i, v1: block_lo_i};

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam logic [xtea_pkg::WORD_W-1:0] EncSum = xtea_pkg::enc_sum(s);
    localparam logic [xtea_pkg::WORD_W-1:0] DecSum = xtea_pkg::dec_sum(s);
    localparam logic [xtea_pkg::IDX_W-1:0]  EncSel = xtea_pkg::enc_ksel(s);
    localparam logic [xtea_pkg::IDX_W-1:0]  DecSel = xtea_pkg::dec_ksel(s);

    logic [xtea_pkg::WORD_W-1:0] enc_rk, dec_rk;
    logic                        vld_in;
    xtea_pkg::stage_t            dat_in;
    logic                        en;

    assign enc_rk = EncSum + key[EncSel];
    assign dec_rk = DecSum + key[DecSel];

    if (s == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign dat_in = in_data;
      assign en     = in_ready_o;
    end else begin : g_rest
      assign vld_in = st_vld[s-1];
      assign dat_in = st_data[s-1];
      assign en     = advance;
    end

    xtea_half_round u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .odd_i    (1'((s % 2) == 1)),
      .enc_rk_i (enc_rk),
      .dec_rk_i (dec_rk),
      .valid_i  (vld_in),
      .data_i   (dat_in),
      .valid_o  (st_vld[s]),
      .data_o   (st_data[s])
    );
  end

  assign out_valid_o = st_vld[N-1];
  assign result_hi_o = st_data[N-1].v0;
  assign result_lo_o = st_data[N-1].v1;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Blocks in flight change only by the transactions on the two channels.
  a_inflight_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |=> ($countones(st_vld) ==
      $past($countones(st_vld)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("blocks in flight lost or duplicated");

  // Hold every stage past the first while the result waits.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> (st_vld[N-1:1] == $past(st_vld[N-1:1])) &&
      $stable(result_hi_o) && $stable(result_lo_o))
    else $error("pipeline moved during stall");

  // Accept into a full first stage only when the pipeline advances.
  a_first_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && st_vld[0] |-> advance)
    else $error("first stage overwritten");

endmodule

// ----- sv/xtea_key_regs.sv -----
// Key register file of the XTEA cipher: four 32-bit words on a plain write port.
// Depends on xtea_pkg.
module xtea_key_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [xtea_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0]         cfg_wdata_i,
  output xtea_pkg::key_t                      key_o
);

  xtea_pkg::key_t key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (xtea_pkg::key_idx_e'(cfg_idx_i))
        xtea_pkg::KEY_WORD0: key_d[0] = cfg_wdata_i;
        xtea_pkg::KEY_WORD1: key_d[1] = cfg_wdata_i;
        xtea_pkg::KEY_WORD2: key_d[2] = cfg_wdata_i;
        xtea_pkg::KEY_WORD3: key_d[3] = cfg_wdata_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ----- sv/xtea_half_round.sv -----
// One registered Feistel half-round of the XTEA pipeline, encrypt or decrypt.
// Depends on xtea_pkg.
module xtea_half_round (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        odd_i,
  input  logic [xtea_pkg::WORD_W-1:0] enc_rk_i,
  input  logic [xtea_pkg::WORD_W-1:0] dec_rk_i,
  input  logic                        valid_i,
  input  xtea_pkg::stage_t            data_i,
  output logic                        valid_o,
  output xtea_pkg::stage_t            data_o
);

  logic                        valid_q, valid_d;
  xtea_pkg::stage_t            data_q, data_d;
  logic                        upd_v0;
  logic [xtea_pkg::WORD_W-1:0] src, tgt, rk, f, res;

  always_comb begin
    upd_v0 = (odd_i == data_i.op);
    src    = upd_v0 ? data_i.v1 : data_i.v0;
    tgt    = upd_v0 ? data_i.v0 : data_i.v1;
    rk     = (data_i.op == xtea_pkg::OP_DECRYPT) ? dec_rk_i : enc_rk_i;
    f      = xtea_pkg::mix(src) ^ rk;
    res    = (data_i.op == xtea_pkg::OP_DECRYPT) ? (tgt - f) : (tgt + f);
    data_d = data_i;
    if (upd_v0) begin
      data_d.v0 = res;
    end else begin
      data_d.v1 = res;
    end
    valid_d = en_i ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
